// File: rtl/core/cse_pkg.sv
package cse_pkg;

   localparam int COEF_W = 24;
   localparam int X_W    = 16;
   localparam int ACC_W  = 32;
   localparam int IDX_W  = 6;
   localparam int DEG_W  = 6;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_EVAL  = 1'b1;

   typedef struct packed {
      logic                     func;
      logic [IDX_W-1:0]         coef_index;
      logic signed [COEF_W-1:0] coef_value;
      logic signed [X_W-1:0]    x_value;
      logic                     end_of_block;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] y_value;
      logic                    overflow;
      logic                    end_of_block_out;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC
   } state_type;

   typedef struct packed {
      logic mul_en;
      logic last;
   } mac_ctrl_type;

endpackage

// File: rtl/core/chebyshev_series_eval.sv
// Channel   Direction  Handshake              Moves
// req       in         req_valid/req_ready    coefficient write or evaluation point
// rsp       out        rsp_valid/rsp_ready    series value, overflow, block marker
// csr       in         csr_wr_en              degree register, no wait
// A coefficient write completes without leaving ST_IDLE. An evaluation runs from c[d] down
// to c0, where d is the degree clamped to MAX_DEGREE, on the shared multiply and add unit
// with a ST_MUL and a ST_ACC step per coefficient. Reset is synchronous and clears the degree
// and control state; the coefficient store stays undefined until written. The result
// register holds one point; a second point waits at its final step until it is free.
module chebyshev_series_eval
   import cse_pkg::*;
#(
   parameter int MAX_DEGREE = 63
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_payload,
   input  logic             csr_wr_en,
   input  logic [DEG_W-1:0] csr_wr_data
);

   localparam int DEPTH = MAX_DEGREE + 1;
   localparam int AW    = $clog2(DEPTH);

   state_type               state_ff, state_in;
   logic [AW-1:0]           k_ff, k_in;
   logic signed [X_W-1:0]   x_ff, x_in;
   logic                    eob_ff, eob_in;
   logic signed [ACC_W-1:0] b1_ff, b1_in;
   logic signed [ACC_W-1:0] b2_ff, b2_in;
   logic                    ovf_ff, ovf_in;
   logic [DEG_W-1:0]        degree_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    rsp_free;
   logic [AW-1:0]           deg_clamped;
   logic                    ram_we;
   logic                    ram_re;
   logic [AW-1:0]           ram_raddr;
   logic [COEF_W-1:0]       ram_rdata;
   mac_ctrl_type            mac_ctrl;
   logic signed [ACC_W-1:0] mac_sum;
   logic                    mac_sat;

   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign deg_clamped = (32'(degree_ff) > MAX_DEGREE) ? AW'(MAX_DEGREE) : AW'(degree_ff);

   cse_ram #(
      .WIDTH(COEF_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(AW'(req_payload.coef_index)),
      .wr_data(req_payload.coef_value),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   cse_mac u_mac (
      .clock    (clock),
      .ctrl     (mac_ctrl),
      .x_value  (x_ff),
      .b1       (b1_ff),
      .b2       (b2_ff),
      .coef     ($signed(ram_rdata)),
      .sum      (mac_sum),
      .saturated(mac_sat)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_payload.func == FUNC_EVAL)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (k_ff != '0) begin
               state_in = ST_MUL;
            end else if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      k_in            = k_ff;
      x_in            = x_ff;
      eob_in          = eob_ff;
      b1_in           = b1_ff;
      b2_in           = b2_ff;
      ovf_in          = ovf_ff;
      ram_we          = 1'b0;
      ram_re          = 1'b0;
      ram_raddr       = k_ff;
      mac_ctrl.mul_en = 1'b0;
      mac_ctrl.last   = (k_ff == '0);
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_in          = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_payload.func == FUNC_WRITE) begin
                  ram_we = (32'(req_payload.coef_index) <= MAX_DEGREE);
               end else begin
                  x_in      = req_payload.x_value;
                  eob_in    = req_payload.end_of_block;
                  b1_in     = '0;
                  b2_in     = '0;
                  ovf_in    = 1'b0;
                  k_in      = deg_clamped;
                  ram_re    = 1'b1;
                  ram_raddr = deg_clamped;
               end
            end
         end
         ST_MUL: begin
            mac_ctrl.mul_en = 1'b1;
         end
         ST_ACC: begin
            if (k_ff != '0) begin
               b2_in     = b1_ff;
               b1_in     = mac_sum;
               ovf_in    = ovf_ff || mac_sat;
               k_in      = k_ff - AW'(1);
               ram_re    = 1'b1;
               ram_raddr = k_ff - AW'(1);
            end else if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_in.y_value          = mac_sum;
               rsp_in.overflow         = ovf_ff || mac_sat;
               rsp_in.end_of_block_out = eob_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         degree_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            degree_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      x_ff   <= x_in;
      eob_ff <= eob_in;
      b1_ff  <= b1_in;
      b2_ff  <= b2_in;
      ovf_ff <= ovf_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_eval_starts_mul: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_payload.func == FUNC_EVAL)) |=> (state_ff == ST_MUL))
      else $error("evaluation transfer did not start the recurrence");

   a_rsp_from_last_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_ready)) |-> ((state_ff == ST_ACC) && (k_ff == '0)))
      else $error("result loaded outside the final recurrence step");

   a_stall_holds_acc: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ACC) && (k_ff == '0) && !rsp_free) |=> ($stable(b1_ff) && $stable(b2_ff)))
      else $error("accumulators changed while the final step waited");

   a_no_write_when_busy: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE))
      else $error("coefficient write during evaluation");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (32'(k_ff) <= MAX_DEGREE))
      else $error("coefficient index beyond the store");
`endif

endmodule

// File: rtl/core/cse_ram.sv
module cse_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/cse_mac.sv
module cse_mac
   import cse_pkg::*;
(
   input  logic                     clock,
   input  mac_ctrl_type             ctrl,
   input  logic signed [X_W-1:0]    x_value,
   input  logic signed [ACC_W-1:0]  b1,
   input  logic signed [ACC_W-1:0]  b2,
   input  logic signed [COEF_W-1:0] coef,
   output logic signed [ACC_W-1:0]  sum,
   output logic                     saturated
);

   localparam int PROD_W = X_W + ACC_W;
   localparam int SUM_W  = ACC_W + 4;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] x_ext;
   logic signed [PROD_W-1:0] b1_ext;
   logic signed [PROD_W-1:0] shifted;
   logic signed [SUM_W-1:0]  total;

   assign x_ext   = {{ACC_W{x_value[X_W-1]}}, x_value};
   assign b1_ext  = {{X_W{b1[ACC_W-1]}}, b1};
   assign prod_in = x_ext * b1_ext;

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // The final step uses x*b rather than 2x*b, so it shifts one place further.
   assign shifted = ctrl.last ? (prod_ff >>> 15) : (prod_ff >>> 14);

   assign total = shifted[SUM_W-1:0]
                - {{(SUM_W-ACC_W){b2[ACC_W-1]}}, b2}
                + {{(SUM_W-COEF_W){coef[COEF_W-1]}}, coef};

   assign saturated = (total[SUM_W-1:ACC_W-1] != '0) && (total[SUM_W-1:ACC_W-1] != '1);

   always_comb begin
      if (!saturated) begin
         sum = total[ACC_W-1:0];
      end else if (total[SUM_W-1]) begin
         sum = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         sum = {1'b0, {(ACC_W-1){1'b1}}};
      end
   end

endmodule

// File: dv/chebyshev_series_eval_test.sv
module chebyshev_series_eval_test;
   import cse_pkg::*;

   localparam int MAX_DEG = 63;
   localparam int CLK_PERIOD = 8;
   localparam int DRAIN_CYCLES = 2 * (MAX_DEG + 1) + 8;
   localparam int HOLD_CYCLES = 300;
   localparam int REPORT_LIMIT = 10;
   localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
   localparam logic signed [X_W-1:0] X_MAX = {1'b0, {(X_W-1){1'b1}}};
   localparam logic signed [X_W-1:0] X_MIN = {1'b1, {(X_W-1){1'b0}}};
   localparam longint ACC_MAX = 64'sd2147483647;
   localparam longint ACC_MIN = -64'sd2147483648;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic [DEG_W-1:0] csr_wr_data = '0;

   logic signed [COEF_W-1:0] coef_mirror [0:MAX_DEG];
   int degree_mirror = 0;
   rsp_type series_results_q[$];
   int fail_count = 0;
   int req_idle_pct = 9;
   int rsp_idle_pct = 66;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;

   chebyshev_series_eval #(
      .MAX_DEGREE(MAX_DEG)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   initial begin
      #(CLK_PERIOD * 1000000);
      $display("Test completed with failures");
      $finish;
   end

   function automatic longint clamp_acc(input longint v, inout bit sat);
      if (v > ACC_MAX) begin
         sat = 1'b1;
         return ACC_MAX;
      end
      if (v < ACC_MIN) begin
         sat = 1'b1;
         return ACC_MIN;
      end
      return v;
   endfunction

   function automatic rsp_type evaluate_series(input logic signed [X_W-1:0] x, input logic eob);
      longint xv;
      longint b1;
      longint b2;
      longint t;
      bit sat;
      int k;
      rsp_type r;
      xv = x;
      b1 = 0;
      b2 = 0;
      sat = 1'b0;
      for (k = degree_mirror; k > 0; k--) begin
         t = ((xv * b1) >>> 14) - b2 + longint'(coef_mirror[k]);
         t = clamp_acc(t, sat);
         b2 = b1;
         b1 = t;
      end
      t = ((xv * b1) >>> 15) - b2 + longint'(coef_mirror[0]);
      t = clamp_acc(t, sat);
      r.y_value = ACC_W'(t);
      r.overflow = sat;
      r.end_of_block_out = eob;
      return r;
   endfunction

   function automatic logic signed [COEF_W-1:0] rand_coef();
      int v;
      case ($urandom_range(5))
         0: v = int'(COEF_MAX);
         1: v = int'(COEF_MIN);
         2, 3: v = $urandom_range(262143) - 131072;
         default: v = $urandom;
      endcase
      return COEF_W'(v);
   endfunction

   function automatic logic signed [X_W-1:0] rand_point();
      case ($urandom_range(5))
         0: return X_MAX;
         1: return X_MIN;
         2: return '0;
         default: return X_W'($urandom);
      endcase
   endfunction

   task automatic send_item(input req_type item);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      if (item.func == FUNC_WRITE) begin
         coef_mirror[item.coef_index] = item.coef_value;
      end else begin
         series_results_q.push_back(evaluate_series(item.x_value, item.end_of_block));
      end
   endtask

   task automatic write_coef(input logic [IDX_W-1:0] idx, input logic signed [COEF_W-1:0] v);
      req_type item;
      item.func = FUNC_WRITE;
      item.coef_index = idx;
      item.coef_value = v;
      item.x_value = X_W'($urandom);
      item.end_of_block = 1'($urandom);
      send_item(item);
   endtask

   task automatic eval_point(input logic signed [X_W-1:0] x, input logic eob);
      req_type item;
      item.func = FUNC_EVAL;
      item.coef_index = IDX_W'($urandom);
      item.coef_value = COEF_W'($urandom);
      item.x_value = x;
      item.end_of_block = eob;
      send_item(item);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (series_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_degree(input int d);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= DEG_W'(d);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      degree_mirror = d;
   endtask

   // The degree register comes out of reset at zero, so only c0 is read.
   task automatic test_reset_degree();
      write_coef(IDX_W'(0), COEF_MAX);
      eval_point(X_MAX, 1'b0);
      eval_point(X_MIN, 1'b1);
      write_coef(IDX_W'(MAX_DEG), COEF_MIN);
      write_coef(IDX_W'(0), COEF_MIN);
      eval_point('0, 1'b1);
   endtask

   task automatic test_short_series();
      write_coef(IDX_W'(1), COEF_MIN);
      write_coef(IDX_W'(2), COEF_MAX);
      set_degree(2);
      eval_point(X_MAX, 1'b0);
      eval_point(X_MIN, 1'b0);
      eval_point('0, 1'b1);
      eval_point(16'sh4000, 1'b1);
      set_degree(1);
      eval_point(X_MAX, 1'b1);
      eval_point(-16'sh2000, 1'b0);
   endtask

   task automatic test_saturation();
      int k;
      set_degree(MAX_DEG);
      for (k = 0; k <= MAX_DEG; k++) write_coef(IDX_W'(k), COEF_MAX);
      eval_point(X_MAX, 1'b0);
      eval_point(X_MIN, 1'b0);
      eval_point('0, 1'b1);
      for (k = 0; k <= MAX_DEG; k++) write_coef(IDX_W'(k), COEF_MIN);
      eval_point(X_MAX, 1'b1);
      eval_point(X_MIN, 1'b0);
      eval_point(16'sh0100, 1'b1);
   endtask

   // Results pile up behind a long receiver stall and the input must stall too.
   task automatic test_backpressure();
      int i;
      set_degree(4);
      req_idle_pct = 0;
      hold_token <= hold_token + 1;
      for (i = 0; i < 24; i++) eval_point(rand_point(), i % 4 == 3);
      wait_drained();
      req_idle_pct = 9;
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int quota);
      int phase;
      int d;
      int sent;
      int n_writes;
      int n_points;
      int i;
      req_idle_pct = sender_pct;
      rsp_idle_pct = receiver_pct;
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: d = $urandom_range(7);
            1: d = $urandom_range(62, 8);
            default: d = ($urandom_range(1) == 1) ? MAX_DEG : 0;
         endcase
         set_degree(d);
         sent = 0;
         while (sent < quota / 3) begin
            if ($urandom_range(9) < 8) begin
               n_writes = $urandom_range(3);
               for (i = 0; i < n_writes; i++) write_coef(IDX_W'($urandom_range(d)), rand_coef());
               n_points = $urandom_range(6, 1);
               for (i = 0; i < n_points; i++) eval_point(rand_point(), i == n_points - 1);
               sent += n_writes + n_points;
            end else begin
               if ($urandom_range(1) == 1) begin
                  write_coef(IDX_W'($urandom), rand_coef());
               end else begin
                  eval_point(rand_point(), 1'($urandom));
               end
               sent++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (hold_seen != hold_token) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (series_results_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
               $display("Unexpected result transfer: y=%0d ovf=%0b eob=%0b",
                        rsp_payload.y_value, rsp_payload.overflow,
                        rsp_payload.end_of_block_out);
            end
         end else begin
            want = series_results_q.pop_front();
            if (rsp_payload.y_value !== want.y_value || rsp_payload.overflow !== want.overflow
                || rsp_payload.end_of_block_out !== want.end_of_block_out) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("Mismatch: expected y=%0d ovf=%0b eob=%0b, got y=%0d ovf=%0b eob=%0b",
                           want.y_value, want.overflow, want.end_of_block_out,
                           rsp_payload.y_value, rsp_payload.overflow,
                           rsp_payload.end_of_block_out);
               end
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_degree();
      test_short_series();
      test_saturation();
      test_backpressure();
      test_random_traffic(9, 66, 255);
      test_random_traffic(66, 9, 255);
      test_random_traffic(0, 0, 255);
      wait_drained();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
